// File: sv/password_policy_checker_top_defines.svh
// Assertion macros shared by the password policy checker RTL.
// Included by the top level; expects clk and arst_n in scope.
`ifndef PASSWORD_POLICY_CHECKER_TOP_DEFINES_SVH
`define PASSWORD_POLICY_CHECKER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define PPC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define PPC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/ppc_pkg.sv
// Shared types, constants and the character classifier of the password policy checker.
// No dependencies.
package ppc_pkg;

	// Default saturation point of the length counter and default queue depth
	localparam int unsigned MaxLengthDefault  = 255;
	localparam int unsigned QueueDepthDefault = 2;

	// Character class bits
	localparam logic [3:0] ClassLower   = 4'b0001;
	localparam logic [3:0] ClassUpper   = 4'b0010;
	localparam logic [3:0] ClassDigit   = 4'b0100;
	localparam logic [3:0] ClassSpecial = 4'b1000;
	localparam logic [3:0] ClassAlnum   = ClassLower | ClassUpper | ClassDigit;

	// Configuration register indexes
	typedef enum logic [2:0] {
		CfgMinLength   = 3'd0,
		CfgMaxLength   = 3'd1,
		CfgClassCount  = 3'd2,
		CfgRequireMask = 3'd3,
		CfgForbidMask  = 3'd4,
		CfgMaxRepeat   = 3'd5,
		CfgMaxSequence = 3'd6
	} ppc_cfg_idx_t;

	// Policy registers as seen by the back end
	typedef struct packed {
		logic [7:0] min_length;
		logic [7:0] max_length;
		logic [2:0] class_count;
		logic [3:0] require_mask;
		logic [3:0] forbid_mask;
		logic [7:0] max_repeat;
		logic [7:0] max_sequence;
	} ppc_cfg_t;

	// One classified byte travelling through the queue
	typedef struct packed {
		logic [7:0] char_code;
		logic [3:0] classes;
		logic       last_char;
	} ppc_item_t;

	// Class of one byte; zero for anything outside the four classes
	function automatic logic [3:0] class_of(input logic [7:0] c);
		logic [3:0] cls;
		cls = '0;
		if (c >= 8'h61 && c <= 8'h7A) begin
			cls = ClassLower;
		end else if (c >= 8'h41 && c <= 8'h5A) begin
			cls = ClassUpper;
		end else if (c >= 8'h30 && c <= 8'h39) begin
			cls = ClassDigit;
		end else begin
			// ! @ # $ % ^ & * ( ) and full stop
			unique case (c)
				8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
				8'h26, 8'h2A, 8'h28, 8'h29, 8'h2E: cls = ClassSpecial;
				default:                            cls = '0;
			endcase
		end
		return cls;
	endfunction

endpackage

// File: sv/ppc_front.sv
// Front end: takes bytes from the input channel and classifies them into queue items.
// Depends on ppc_pkg.
module ppc_front import ppc_pkg::*; (
	input  logic       byte_valid,
	output logic       byte_stall,
	input  logic [7:0] char_code,
	input  logic       last_char,
	input  logic       q_full,
	output logic       push,
	output ppc_item_t  push_item
);

	// Hold the sender off only when there is no room in the queue
	assign byte_stall = q_full;
	assign push       = byte_valid && !q_full;

	// Classify on the way in so the back end sees class bits directly
	always_comb begin
		push_item.char_code = char_code;
		push_item.classes   = class_of(char_code);
		push_item.last_char = last_char;
	end

endmodule

// File: sv/ppc_queue.sv
// Short FIFO of classified bytes between front and back end.
// Depends on ppc_pkg.
module ppc_queue import ppc_pkg::*; #(
	parameter int unsigned DEPTH = QueueDepthDefault
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  ppc_item_t push_item,
	input  logic      pop,
	output logic      q_valid,
	output logic      q_full,
	output ppc_item_t q_item
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	ppc_item_t       store_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign q_valid = (count_q != '0);
	assign q_full  = (count_q == CW'(DEPTH));
	assign q_item  = store_q[rd_ptr_q];

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			store_q[wr_ptr_q] <= push_item;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: sv/ppc_back.sv
// Back end: per-password tracking state, rule evaluation and the result register.
// Depends on ppc_pkg.
module ppc_back import ppc_pkg::*; #(
	parameter int unsigned MAX_LENGTH = MaxLengthDefault
) (
	input  logic      clk,
	input  logic      arst_n,
	input  ppc_cfg_t  cfg,
	input  logic      q_valid,
	input  ppc_item_t q_item,
	output logic      pop,
	output logic      result_valid,
	input  logic      result_stall,
	output logic      accepted
);

	localparam int unsigned LW = $clog2(MAX_LENGTH + 1);
	localparam int unsigned KW = (LW > 8) ? LW : 8;

	logic [LW-1:0] length_q;
	logic [3:0]    seen_q;
	logic [7:0]    prev_q;
	logic          prev_alnum_q;
	logic [7:0]    repeat_q;
	logic [7:0]    sequence_q;
	logic          broken_q;
	logic          mid_word_q;
	logic          result_valid_q;
	logic          accepted_q;

	logic [LW-1:0] length_d;
	logic [3:0]    seen_d;
	logic [7:0]    repeat_d;
	logic [7:0]    sequence_d;
	logic          broken_d;
	logic [8:0]    rep_inc;
	logic [8:0]    seq_inc;
	logic [2:0]    n_classes;
	logic          ok;

	// A last byte needs the result register free or draining this cycle
	assign pop = q_valid && (!q_item.last_char || !result_valid_q || !result_stall);

	// Next tracking state for the byte at the head of the queue
	always_comb begin
		rep_inc    = {1'b0, repeat_q} + 9'd1;
		seq_inc    = {1'b0, sequence_q} + 9'd1;
		length_d   = LW'(1);
		repeat_d   = 8'd1;
		sequence_d = 8'd1;
		broken_d   = 1'b0;
		seen_d     = q_item.classes;
		if (mid_word_q) begin
			length_d   = (length_q < LW'(MAX_LENGTH)) ? length_q + 1'b1 : length_q;
			broken_d   = broken_q;
			seen_d     = seen_q | q_item.classes;
			sequence_d = sequence_q;
			// repeat run
			if (q_item.char_code == prev_q) begin
				repeat_d = rep_inc[8] ? 8'd255 : rep_inc[7:0];
				if (cfg.max_repeat != '0 && rep_inc > {1'b0, cfg.max_repeat}) begin
					broken_d = 1'b1;
				end
			end
			// ascending run, only after an alphanumeric byte
			if (prev_alnum_q) begin
				if ({1'b0, q_item.char_code} == {1'b0, prev_q} + 9'd1) begin
					sequence_d = seq_inc[8] ? 8'd255 : seq_inc[7:0];
					if (cfg.max_sequence != '0 && seq_inc > {1'b0, cfg.max_sequence}) begin
						broken_d = 1'b1;
					end
				end else begin
					sequence_d = 8'd1;
				end
			end
		end
	end

	// Verdict on the password that ends with this byte
	always_comb begin
		n_classes = {2'b0, seen_d[0]} + {2'b0, seen_d[1]}
		          + {2'b0, seen_d[2]} + {2'b0, seen_d[3]};
		ok = !broken_d;
		if (cfg.min_length != '0 && KW'(length_d) < KW'(cfg.min_length)) ok = 1'b0;
		if (cfg.max_length != '0 && KW'(length_d) > KW'(cfg.max_length)) ok = 1'b0;
		if (cfg.class_count != '0 && n_classes < cfg.class_count) ok = 1'b0;
		if ((seen_d & cfg.require_mask) != cfg.require_mask) ok = 1'b0;
		if ((seen_d & cfg.forbid_mask) != '0) ok = 1'b0;
	end

	// Tracking state; the first byte of a password overwrites all of it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_q     <= '0;
			seen_q       <= '0;
			prev_q       <= '0;
			prev_alnum_q <= 1'b0;
			repeat_q     <= 8'd1;
			sequence_q   <= 8'd1;
			broken_q     <= 1'b0;
			mid_word_q   <= 1'b0;
		end else if (pop) begin
			length_q     <= length_d;
			seen_q       <= seen_d;
			prev_q       <= q_item.char_code;
			prev_alnum_q <= (q_item.classes & ClassAlnum) != '0;
			repeat_q     <= repeat_d;
			sequence_q   <= sequence_d;
			broken_q     <= broken_d;
			mid_word_q   <= !q_item.last_char;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (pop && q_item.last_char) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && q_item.last_char) begin
			accepted_q <= ok;
		end
	end

	assign result_valid = result_valid_q;
	assign accepted     = accepted_q;

endmodule

// File: sv/password_policy_checker_top.sv
// Password policy checker: top level with the policy registers and assertions.
// Depends on ppc_pkg, ppc_front, ppc_queue, ppc_back and the shared defines header.
//
// Usage:
//   Bytes of a password arrive on byte_valid/byte_stall with char_code and
//   last_char; last_char marks the final byte. One result (accepted) per
//   password leaves on result_valid/result_stall.
//   Policy registers are written over cfg_valid/cfg_ready with cfg_index and
//   cfg_data; cfg_ready is always high. The user must write them only while no
//   password is in flight; the block does not enforce this. Throughput: one
//   byte per cycle while byte_stall stays low. Each byte updates a handful of
//   counters and flags in the back end. The queue takes the last byte on the
//   edge that accepts it; the back end pops it once the result register is free
//   or draining and loads the verdict there, which raises result_valid.
//   When the receiver stalls, the result holds in its register; bytes of the
//   next password keep flowing until a second last byte reaches the head of
//   the queue, after which the queue fills and byte_stall rises.
//   Reset clears all policy registers (every rule off), empties the queue and
//   drops any partial password.
`include "password_policy_checker_top_defines.svh"

module password_policy_checker_top import ppc_pkg::*; #(
	parameter int unsigned MAX_LENGTH  = MaxLengthDefault,
	parameter int unsigned QUEUE_DEPTH = QueueDepthDefault
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       byte_valid,
	output logic       byte_stall,
	input  logic [7:0] char_code,
	input  logic       last_char,
	output logic       result_valid,
	input  logic       result_stall,
	output logic       accepted,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [2:0] cfg_index,
	input  logic [7:0] cfg_data
);

	ppc_cfg_t  cfg_q;
	logic      push;
	ppc_item_t push_item;
	logic      pop;
	logic      q_valid;
	logic      q_full;
	ppc_item_t q_item;

	assign cfg_ready = 1'b1;

	// Policy registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (ppc_cfg_idx_t'(cfg_index))
				CfgMinLength:   cfg_q.min_length   <= cfg_data;
				CfgMaxLength:   cfg_q.max_length   <= cfg_data;
				CfgClassCount:  cfg_q.class_count  <= cfg_data[2:0];
				CfgRequireMask: cfg_q.require_mask <= cfg_data[3:0];
				CfgForbidMask:  cfg_q.forbid_mask  <= cfg_data[3:0];
				CfgMaxRepeat:   cfg_q.max_repeat   <= cfg_data;
				CfgMaxSequence: cfg_q.max_sequence <= cfg_data;
				default: ;
			endcase
		end
	end

	ppc_front u_front (
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.char_code  (char_code),
		.last_char  (last_char),
		.q_full     (q_full),
		.push       (push),
		.push_item  (push_item)
	);

	ppc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.q_valid   (q_valid),
		.q_full    (q_full),
		.q_item    (q_item)
	);

	ppc_back #(
		.MAX_LENGTH (MAX_LENGTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.q_valid      (q_valid),
		.q_item       (q_item),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.accepted     (accepted)
	);

	// A result only ever follows a last byte leaving the queue
	`PPC_ASSERT_NOW(a_result_from_last, $rose(result_valid), $past(pop && q_item.last_char), "result without a last byte")

	// The back end never takes from an empty queue
	`PPC_ASSERT_NOW(a_pop_not_empty, pop, q_valid, "pop from empty queue")

	// A last byte is never taken while a stalled result still occupies the register
	`PPC_ASSERT_NOW(a_no_overwrite, result_valid && result_stall && q_valid && q_item.last_char, !pop, "result overwritten while stalled")

	// A stalled result carries into the next cycle
	`PPC_ASSERT_NEXT(a_result_held, result_valid && result_stall, result_valid, "stalled result dropped")

endmodule

// File: sim/password_policy_checker_top_test.sv
// Self-checking testbench for password_policy_checker_top: streams passwords over the
// byte channel, predicts each verdict and checks every result transaction.
// Depends on ppc_pkg and the password_policy_checker_top RTL.
module password_policy_checker_top_test;
	timeunit 1ns;
	timeprecision 1ps;
	import ppc_pkg::*;

	localparam int unsigned LengthCap     = MaxLengthDefault;
	localparam int unsigned RandomBytes   = 1750;
	localparam int unsigned ResultLatency = 2;
	localparam logic [8*11-1:0] SpecialChars = "!@#$%^&*().";

	typedef struct packed {
		logic [7:0] code;
		logic       last;
		logic       hold;	// wait for every verdict before offering this byte
	} pw_byte_t;

	typedef enum int {WordMixed, WordNoise, WordRun} word_style_t;

	// Block ports
	logic       clk          = 1'b0;
	logic       arst_n       = 1'b0;
	logic       byte_valid   = 1'b0;
	logic [7:0] char_code    = 8'd0;
	logic       last_char    = 1'b0;
	logic       result_stall = 1'b0;
	logic       cfg_valid    = 1'b0;
	logic [2:0] cfg_index    = CfgMinLength;
	logic [7:0] cfg_data     = 8'd0;
	logic       byte_stall;
	logic       result_valid;
	logic       accepted;
	logic       cfg_ready;

	// Predictor state and the policy it judges against
	ppc_cfg_t   policy = '0;
	logic [7:0] word_len   = 8'd0;
	logic [7:0] prev_code  = 8'd0;
	logic [7:0] repeat_len = 8'd1;
	logic [7:0] ascent_len = 8'd1;
	logic [3:0] seen       = 4'd0;
	logic       broken     = 1'b0;
	logic       in_word    = 1'b0;

	logic        verdict_q[$];
	pw_byte_t    pending[$];
	int unsigned byte_offered = 0;
	int unsigned byte_taken   = 0;
	int unsigned failures     = 0;
	int unsigned bytes_queued = 0;
	int unsigned gap_left     = 0;
	int unsigned burst_left   = 0;
	int unsigned rx_cycle     = 0;
	bit          tx_bursty    = 1'b0;
	int          rx_pattern   = 0;

	password_policy_checker_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.byte_stall   (byte_stall),
		.char_code    (char_code),
		.last_char    (last_char),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.accepted     (accepted),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Class bit of one byte, zero outside the four classes
	function automatic logic [3:0] class_bits(input logic [7:0] c);
		if (c >= "a" && c <= "z") return ClassLower;
		if (c >= "A" && c <= "Z") return ClassUpper;
		if (c >= "0" && c <= "9") return ClassDigit;
		case (c)
			"!", "@", "#", "$", "%", "^", "&", "*", "(", ")", ".": return ClassSpecial;
			default: return 4'b0000;
		endcase
	endfunction

	// Fold one accepted byte into the word state; on the last byte queue the verdict
	task automatic judge_byte(input logic [7:0] c, input logic last);
		logic [8:0] step;
		logic [2:0] n_classes;
		logic       ok;
		if (!in_word) begin
			word_len   = 8'd1;
			seen       = 4'd0;
			repeat_len = 8'd1;
			ascent_len = 8'd1;
			broken     = 1'b0;
			in_word    = 1'b1;
		end else begin
			if (word_len < LengthCap) word_len = word_len + 8'd1;
			if (c == prev_code) begin
				step = {1'b0, repeat_len} + 9'd1;
				if (policy.max_repeat != 0 && step > policy.max_repeat) broken = 1'b1;
				repeat_len = (step > 9'd255) ? 8'd255 : step[7:0];
			end else begin
				repeat_len = 8'd1;
			end
			// only a letter or digit can start or extend an ascending step
			if ((class_bits(prev_code) & ClassAlnum) != 0) begin
				if ({1'b0, c} == {1'b0, prev_code} + 9'd1) begin
					step = {1'b0, ascent_len} + 9'd1;
					if (policy.max_sequence != 0 && step > policy.max_sequence) broken = 1'b1;
					ascent_len = (step > 9'd255) ? 8'd255 : step[7:0];
				end else begin
					ascent_len = 8'd1;
				end
			end
		end
		seen      = seen | class_bits(c);
		prev_code = c;
		if (last) begin
			n_classes = {2'b0, seen[0]} + {2'b0, seen[1]} + {2'b0, seen[2]} + {2'b0, seen[3]};
			ok = !broken;
			if (policy.min_length != 0 && word_len < policy.min_length) ok = 1'b0;
			if (policy.max_length != 0 && word_len > policy.max_length) ok = 1'b0;
			if (policy.class_count != 0 && n_classes < policy.class_count) ok = 1'b0;
			if ((seen & policy.require_mask) != policy.require_mask) ok = 1'b0;
			if ((seen & policy.forbid_mask) != 0) ok = 1'b0;
			verdict_q.push_back(ok);
			in_word = 1'b0;
		end
	endtask

	// Monitor: config writes, accepted bytes and result transactions
	always @(posedge clk) begin : watch
		logic want;
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				if (verdict_q.size() == 0) begin
					$error("accepted: no verdict expected, got %0b", accepted);
					failures++;
				end else begin
					want = verdict_q.pop_front();
					if (accepted !== want) begin
						$error("accepted: expected %0b, got %0b", want, accepted);
						failures++;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (ppc_cfg_idx_t'(cfg_index))
					CfgMinLength:   policy.min_length   = cfg_data;
					CfgMaxLength:   policy.max_length   = cfg_data;
					CfgClassCount:  policy.class_count  = cfg_data[2:0];
					CfgRequireMask: policy.require_mask = cfg_data[3:0];
					CfgForbidMask:  policy.forbid_mask  = cfg_data[3:0];
					CfgMaxRepeat:   policy.max_repeat   = cfg_data;
					CfgMaxSequence: policy.max_sequence = cfg_data;
					default: ;
				endcase
			end
			if (byte_valid && !byte_stall) begin
				judge_byte(char_code, last_char);
				byte_taken++;
			end
		end
	end

	// Byte driver: fed from the pending queue, in bursts with random gaps when tx_bursty is set
	always @(negedge clk) begin : sender
		pw_byte_t nxt;
		if (arst_n && (!byte_valid || byte_taken == byte_offered)) begin
			if (gap_left != 0) begin
				gap_left--;
				byte_valid <= 1'b0;
			end else if (pending.size() != 0 && !(pending[0].hold && verdict_q.size() != 0)) begin
				nxt = pending.pop_front();
				char_code  <= nxt.code;
				last_char  <= nxt.last;
				byte_valid <= 1'b1;
				byte_offered++;
				if (burst_left != 0) begin
					burst_left--;
				end else if (tx_bursty) begin
					burst_left = $urandom_range(0, 15);
					gap_left   = $urandom_range(1, 8);
				end
			end else begin
				byte_valid <= 1'b0;
			end
		end
	end

	// Result receiver: a long hold-off that recurs periodically, otherwise the phase pattern
	always @(negedge clk) begin : receiver
		rx_cycle <= rx_cycle + 1;
		if (rx_cycle % 1024 >= 512 && rx_cycle % 1024 < 612) begin
			result_stall <= 1'b1;
		end else begin
			case (rx_pattern)
				0:       result_stall <= 1'b0;
				1:       result_stall <= ($urandom_range(0, 3) == 0);
				2:       result_stall <= 1'($urandom_range(0, 1));
				default: result_stall <= (rx_cycle % 7) < 3;
			endcase
		end
	end

	task automatic queue_byte(input logic [7:0] c, input logic last, input logic hold);
		pw_byte_t b;
		b.code = c;
		b.last = last;
		b.hold = hold;
		pending.push_back(b);
		bytes_queued++;
	endtask

	task automatic queue_text(input string s);
		for (int i = 0; i < s.len(); i++) queue_byte(s[i], i == s.len() - 1, 1'b0);
	endtask

	function automatic logic [7:0] pick_char();
		case ($urandom_range(0, 4))
			0:       return 8'h61 + 8'($urandom_range(0, 25));
			1:       return 8'h41 + 8'($urandom_range(0, 25));
			2:       return 8'h30 + 8'($urandom_range(0, 9));
			3:       return SpecialChars[8*$urandom_range(0, 10) +: 8];
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// One password of the given style; mixed words carry repeats and ascending steps
	task automatic queue_word(input int len, input word_style_t style, input logic hold);
		logic [7:0] c;
		logic [7:0] p;
		int         r;
		p = pick_char();
		for (int i = 0; i < len; i++) begin
			r = $urandom_range(0, 9);
			case (style)
				WordNoise: c = 8'($urandom_range(0, 255));
				WordRun:   c = p;
				default: begin
					if (i > 0 && r < 2) c = p;
					else if (i > 0 && r < 4) c = p + 8'd1;
					else c = pick_char();
				end
			endcase
			queue_byte(c, i == len - 1, hold && i == 0);
			p = c;
		end
	endtask

	task automatic random_word(input logic hold);
		if ($urandom_range(0, 9) < 7) queue_word($urandom_range(1, 16), WordMixed, hold);
		else queue_word($urandom_range(1, 10), WordNoise, hold);
	endtask

	function automatic ppc_cfg_t random_policy();
		ppc_cfg_t p;
		p.min_length   = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(1, 10));
		p.max_length   = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(4, 24));
		p.class_count  = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) :
		                 3'($urandom_range(0, 2));
		p.require_mask = 4'($urandom_range(0, 15) & $urandom_range(0, 15));
		p.forbid_mask  = ($urandom_range(0, 2) == 0) ? 4'($urandom_range(0, 15)) : 4'd0;
		p.max_repeat   = ($urandom_range(0, 3) == 0) ? 8'd0 :
		                 ($urandom_range(0, 5) == 0) ? 8'd255 : 8'($urandom_range(1, 4));
		p.max_sequence = ($urandom_range(0, 3) == 0) ? 8'd0 :
		                 ($urandom_range(0, 5) == 0) ? 8'd255 : 8'($urandom_range(1, 5));
		return p;
	endfunction

	task automatic write_reg(input ppc_cfg_idx_t idx, input logic [7:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	task automatic load_policy(input ppc_cfg_t p);
		write_reg(CfgMinLength, p.min_length);
		write_reg(CfgMaxLength, p.max_length);
		write_reg(CfgClassCount, {5'd0, p.class_count});
		write_reg(CfgRequireMask, {4'd0, p.require_mask});
		write_reg(CfgForbidMask, {4'd0, p.forbid_mask});
		write_reg(CfgMaxRepeat, p.max_repeat);
		write_reg(CfgMaxSequence, p.max_sequence);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Wait until every byte is taken and every verdict is in, then let the pipe empty
	task automatic settle();
		while (pending.size() != 0 || byte_taken != byte_offered || verdict_q.size() != 0)
			@(posedge clk);
		repeat (ResultLatency + 2) @(posedge clk);
	endtask

	initial begin : stimulus
		ppc_cfg_t pol;
		int       phase;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset policy: byte extremes and a single-byte password
		queue_byte(8'h00, 1'b1, 1'b0);
		queue_byte(8'hFF, 1'b1, 1'b0);
		queue_text("a");
		settle();

		// Tight policy: repeat and ascending limits, short word, forbidden class,
		// ascending step onto a non-alphanumeric byte
		pol = '0;
		pol.min_length   = 8'd3;
		pol.max_length   = 8'd6;
		pol.class_count  = 3'd2;
		pol.require_mask = ClassLower;
		pol.forbid_mask  = ClassSpecial;
		pol.max_repeat   = 8'd2;
		pol.max_sequence = 8'd3;
		load_policy(pol);
		queue_text("aaab");
		queue_text("abcd");
		queue_text("a1");
		queue_text("aB3");
		queue_text("a.b");
		queue_text("a9:;");
		settle();

		// Class count above four can never be met
		pol.class_count = 3'd5;
		pol.forbid_mask = 4'd0;
		load_policy(pol);
		queue_text("aB3!");
		settle();

		// Random phases, each with its own policy and idling pattern
		bytes_queued = 0;
		phase = 0;
		while (bytes_queued < RandomBytes) begin
			case (phase)
				2: begin
					pol = '0;
					pol.min_length   = 8'd255;
					pol.max_length   = 8'd255;
					pol.max_repeat   = 8'd255;
					pol.max_sequence = 8'd255;
				end
				5: begin
					pol = '0;
					pol.class_count  = 3'd7;
					pol.require_mask = 4'hF;
					pol.forbid_mask  = 4'hF;
				end
				default: pol = random_policy();
			endcase
			tx_bursty  = (phase % 3 != 0);
			rx_pattern = phase % 4;
			load_policy(pol);
			// long words: saturated length and a run that passes 255
			if (phase == 2) begin
				queue_word(260, WordRun, 1'b0);
				queue_word(270, WordNoise, 1'b0);
			end
			for (int k = 0; k < 24; k++) random_word(k == 12 || $urandom_range(0, 19) == 0);
			settle();
			phase++;
		end

		if (verdict_q.size() != 0) begin
			$error("accepted: %0d verdicts never arrived", verdict_q.size());
			failures++;
		end
		if (failures == 0) begin
			$display("password_policy_checker_top test passed");
		end else begin
			$display("password_policy_checker_top test failed");
		end
		$finish;
	end

	initial begin : watchdog
		#8_000_000;
		$display("password_policy_checker_top test failed");
		$finish;
	end

endmodule
